>>> design/pvdo_pkg.sv
// ----------------------------------------------------------------------------
// pvdo_pkg: shared types, constants and saturation helpers
// Fixed-point formats, register codes and the request/response structs of the
// shared coefficient multiplier.
// ----------------------------------------------------------------------------
package pvdo_pkg;

  localparam int unsigned DataW   = 32;  // Q16.16 velocities and currents
  localparam int unsigned WideW   = 48;  // Q32.16 accumulators
  localparam int unsigned CoefW   = 32;  // unsigned Q8.24 coefficients
  localparam int unsigned GainW   = 25;  // observer filter gain
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned AccW    = 80;
  localparam int unsigned FracW   = 24;
  localparam int unsigned ResW    = 57;  // signed product back in Q.16

  localparam logic [AccW-1:0] RoundHalf = AccW'(64'd8388608);

  localparam logic signed [63:0] Max48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Min48 = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] Max32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Min32 = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_VELOCITY = 8'd0,
    REG_KP           = 8'd1,
    REG_KI_DT        = 8'd2,
    REG_KD_OVER_DT   = 8'd3,
    REG_INERTIA_KT   = 8'd4,
    REG_DOB_VEL_COEF = 8'd5,
    REG_DOB_GAIN     = 8'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DataW-1:0] ref_velocity;
    logic [CoefW-1:0]        kp;
    logic [CoefW-1:0]        ki_dt;
    logic [CoefW-1:0]        kd_over_dt;
    logic [CoefW-1:0]        inertia_over_torque_const;
    logic [CoefW-1:0]        dob_velocity_coeff;
    logic [GainW-1:0]        dob_filter_gain;
  } cfg_t;

  typedef struct packed {
    logic                    go;
    logic signed [WideW-1:0] a;
    logic [CoefW-1:0]        k;
  } mul_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [ResW-1:0] res;
  } mul_rsp_t;

  function automatic logic signed [WideW-1:0] sat48(input logic signed [63:0] v);
    logic signed [WideW-1:0] r;
    if (v > Max48) begin
      r = Max48[WideW-1:0];
    end else if (v < Min48) begin
      r = Min48[WideW-1:0];
    end else begin
      r = v[WideW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > Max32) begin
      r = Max32[DataW-1:0];
    end else if (v < Min32) begin
      r = Min32[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/pid_velocity_with_disturbance_observer.sv
// ----------------------------------------------------------------------------
// pid_velocity_with_disturbance_observer: velocity PID with observer
// Sequencer and datapath of the velocity loop and the first-order disturbance
// observer, built around one shared coefficient multiplier.
// ----------------------------------------------------------------------------
// Usage: one request on the in_ channel carries the measured velocity of one
// control period (signed Q16.16). The block answers with one result on the
// out_ channel: the current command and the disturbance current, both signed
// Q16.16 and saturated.
// After the accept, each request runs six coefficient products on the shared
// 32x32 multiplier (launch, two partial products, accumulate, sign,
// hand-back), then the additions of the XSUM, IDIS and CMD steps. in_ready
// is high only while the sequencer is idle.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver still stalls when the next result is due, the
// sequencer holds in its last step and commits nothing until the output
// register frees up.
// Reset (synchronous, active low) loads the default coefficients and clears
// the error sum, previous error, observer state and previous current.
// The user must write the cfg_ port only while idle; the block does not check.
// ----------------------------------------------------------------------------
module pid_velocity_with_disturbance_observer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pvdo_pkg::DataW-1:0]   in_measured_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pvdo_pkg::DataW-1:0]   out_current_command,
  output logic signed [pvdo_pkg::DataW-1:0]   out_disturbance_current,
  input  logic                                cfg_we,
  input  logic [pvdo_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pvdo_pkg::DataW-1:0]          cfg_wdata
);
  import pvdo_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_MP   = 10'b0000000010,
    ST_MI   = 10'b0000000100,
    ST_MD   = 10'b0000001000,
    ST_MC   = 10'b0000010000,
    ST_XSUM = 10'b0000100000,
    ST_MG   = 10'b0001000000,
    ST_IDIS = 10'b0010000000,
    ST_MJ   = 10'b0100000000,
    ST_CMD  = 10'b1000000000
  } state_t;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  state_t state_r, state_nxt;
  logic   mul_go_r, mul_go_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   commit;

  // Loop state kept from one period to the next.
  logic signed [DataW-1:0] prev_e_r;
  logic signed [WideW-1:0] esum_r;
  logic signed [WideW-1:0] s_r;
  logic signed [DataW-1:0] prev_cur_r;

  // Working registers of the current request.
  logic signed [DataW-1:0] v_r;
  logic signed [DataW-1:0] e_r;
  logic signed [DataW:0]   diff_r;
  logic signed [WideW-1:0] p_r, i_r, d_r, cv_r, x_r, sum_r, sj_r;
  logic signed [DataW-1:0] idis_r;
  logic signed [DataW-1:0] cmd;
  logic signed [DataW-1:0] out_cmd_r, out_dis_r;

  pvdo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pvdo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_CMD) && out_free;
  assign cmd      = sat32(64'(sj_r) + 64'(idis_r));

  always_comb begin
    state_nxt  = state_r;
    mul_go_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt  = ST_MP;
        mul_go_nxt = 1'b1;
      end
      ST_MP: if (mul_rsp.done) begin
        state_nxt  = ST_MI;
        mul_go_nxt = 1'b1;
      end
      ST_MI: if (mul_rsp.done) begin
        state_nxt  = ST_MD;
        mul_go_nxt = 1'b1;
      end
      ST_MD: if (mul_rsp.done) begin
        state_nxt  = ST_MC;
        mul_go_nxt = 1'b1;
      end
      ST_MC: if (mul_rsp.done) state_nxt = ST_XSUM;
      ST_XSUM: begin
        state_nxt  = ST_MG;
        mul_go_nxt = 1'b1;
      end
      ST_MG: if (mul_rsp.done) state_nxt = ST_IDIS;
      ST_IDIS: begin
        state_nxt  = ST_MJ;
        mul_go_nxt = 1'b1;
      end
      ST_MJ: if (mul_rsp.done) state_nxt = ST_CMD;
      ST_CMD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.go = mul_go_r;
    unique case (state_r)
      ST_MP: begin
        mul_req.a = WideW'(e_r);
        mul_req.k = cfg.kp;
      end
      ST_MI: begin
        mul_req.a = esum_r;
        mul_req.k = cfg.ki_dt;
      end
      ST_MD: begin
        mul_req.a = WideW'(diff_r);
        mul_req.k = cfg.kd_over_dt;
      end
      ST_MC: begin
        mul_req.a = WideW'(v_r);
        mul_req.k = cfg.dob_velocity_coeff;
      end
      ST_MG: begin
        mul_req.a = x_r;
        mul_req.k = CoefW'(cfg.dob_filter_gain);
      end
      ST_MJ: begin
        mul_req.a = sum_r;
        mul_req.k = cfg.inertia_over_torque_const;
      end
      default: begin
        mul_req.a = '0;
        mul_req.k = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      prev_e_r    <= '0;
      esum_r      <= '0;
      s_r         <= '0;
      prev_cur_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= mul_go_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        prev_cur_r  <= cmd;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // The error sum and the previous error move on once per request, on
      // the cycle the proportional product is launched.
      if (state_r == ST_MP && mul_go_r) begin
        esum_r   <= sat48(64'(esum_r) + 64'(e_r));
        prev_e_r <= e_r;
      end
      if (state_r == ST_MG && mul_rsp.done) begin
        s_r <= sat48(64'(s_r) + 64'(mul_rsp.res));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      v_r <= in_measured_velocity;
      e_r <= sat32(64'(cfg.ref_velocity) - 64'(in_measured_velocity));
    end
    if (state_r == ST_MP && mul_go_r) begin
      diff_r <= (DataW+1)'(e_r) - (DataW+1)'(prev_e_r);
    end
    if (mul_rsp.done) begin
      unique case (state_r)
        ST_MP: p_r  <= sat48(64'(mul_rsp.res));
        ST_MI: i_r  <= sat48(64'(mul_rsp.res));
        ST_MD: d_r  <= sat48(64'(mul_rsp.res));
        ST_MC: cv_r <= mul_rsp.res[WideW-1:0];
        ST_MJ: sj_r <= sat48(64'(mul_rsp.res));
        default: begin
        end
      endcase
    end
    if (state_r == ST_XSUM) begin
      x_r   <= sat48(64'(prev_cur_r) + 64'(cv_r) - 64'(s_r));
      sum_r <= sat48(64'(p_r) + 64'(i_r) + 64'(d_r));
    end
    if (state_r == ST_IDIS) begin
      idis_r <= sat32(64'(s_r) - 64'(cv_r));
    end
    if (commit) begin
      out_cmd_r <= cmd;
      out_dis_r <= idis_r;
    end
  end

  assign in_ready                = (state_r == ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_current_command     = out_cmd_r;
  assign out_disturbance_current = out_dis_r;

  a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go_r |-> !mul_rsp.busy)
    else $error("multiplier launched while still busy");

  a_done_in_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ST_MP || state_r == ST_MI || state_r == ST_MD ||
                      state_r == ST_MC || state_r == ST_MG || state_r == ST_MJ))
    else $error("multiplier result returned outside a product step");

  a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MP && mul_go_r))
    else $error("accepted request did not start the proportional product");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid && state_r == ST_IDLE))
    else $error("finished request did not reach the output register");

endmodule

>>> design/pvdo_cfg.sv
// ----------------------------------------------------------------------------
// pvdo_cfg: configuration register file
// Set point, loop gains and observer coefficients, written through a plain
// write port. Writes to an unknown index are ignored.
// ----------------------------------------------------------------------------
module pvdo_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pvdo_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pvdo_pkg::DataW-1:0]   cfg_wdata,
  output pvdo_pkg::cfg_t               cfg
);
  import pvdo_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_velocity              <= 32'sd13107200;
      cfg_r.kp                        <= 32'd335544320;
      cfg_r.ki_dt                     <= 32'd0;
      cfg_r.kd_over_dt                <= 32'd27962027;
      cfg_r.inertia_over_torque_const <= 32'd11393;
      cfg_r.dob_velocity_coeff        <= 32'd2278700;
      cfg_r.dob_filter_gain           <= 25'd20133;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_VELOCITY: cfg_r.ref_velocity              <= $signed(cfg_wdata);
        REG_KP:           cfg_r.kp                        <= cfg_wdata;
        REG_KI_DT:        cfg_r.ki_dt                     <= cfg_wdata;
        REG_KD_OVER_DT:   cfg_r.kd_over_dt                <= cfg_wdata;
        REG_INERTIA_KT:   cfg_r.inertia_over_torque_const <= cfg_wdata;
        REG_DOB_VEL_COEF: cfg_r.dob_velocity_coeff        <= cfg_wdata;
        REG_DOB_GAIN:     cfg_r.dob_filter_gain           <= cfg_wdata[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/pvdo_mul.sv
// ----------------------------------------------------------------------------
// pvdo_mul: shared coefficient multiplier
// Multiplies a signed 48-bit value by an unsigned Q8.24 coefficient with one
// 32x32 multiplier over two partial products, rounding to nearest with ties
// away from zero. The LO, HI, ACC and OUT phases lead to the result in PH_DONE.
// ----------------------------------------------------------------------------
module pvdo_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pvdo_pkg::mul_req_t req,
  output pvdo_pkg::mul_rsp_t rsp
);
  import pvdo_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_LO   = 6'b000010,
    PH_HI   = 6'b000100,
    PH_ACC  = 6'b001000,
    PH_OUT  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic                    neg_r;
  logic [WideW-1:0]        mag_r;
  logic [CoefW-1:0]        k_r;
  logic [ProdW-1:0]        prod_r;
  logic [AccW-1:0]         acc_r;
  logic signed [ResW-1:0]  res_r;
  logic [CoefW-1:0]        mul_a;
  logic [ResW-2:0]         rounded;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: if (req.go) phase_nxt = PH_LO;
      PH_LO:   phase_nxt = PH_HI;
      PH_HI:   phase_nxt = PH_ACC;
      PH_ACC:  phase_nxt = PH_OUT;
      PH_OUT:  phase_nxt = PH_DONE;
      PH_DONE: phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // The low word goes through first, then the upper sixteen bits.
  assign mul_a   = (phase_r == PH_HI) ? {{(CoefW-(WideW-32)){1'b0}}, mag_r[WideW-1:32]}
                                      : mag_r[31:0];
  assign rounded = acc_r[AccW-1:FracW];

  always_ff @(posedge clk) begin
    if (req.go) begin
      neg_r <= req.a[WideW-1];
      mag_r <= req.a[WideW-1] ? $unsigned(-req.a) : $unsigned(req.a);
      k_r   <= req.k;
    end
    if (phase_r == PH_LO || phase_r == PH_HI) begin
      prod_r <= mul_a * k_r;
    end
    if (phase_r == PH_HI) begin
      acc_r <= {{(AccW-ProdW){1'b0}}, prod_r} + RoundHalf;
    end
    if (phase_r == PH_ACC) begin
      acc_r <= acc_r + {prod_r[WideW-1:0], 32'b0};
    end
    if (phase_r == PH_OUT) begin
      res_r <= neg_r ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
    end
  end

  assign rsp.busy = (phase_r != PH_IDLE);
  assign rsp.done = (phase_r == PH_DONE);
  assign rsp.res  = res_r;

endmodule
